// ===== rtl/mtt_pkg.sv =====
// Shared types, codes and helpers for the Morton texture tiler.
`timescale 1ns / 1ps

package mtt_pkg;

    // Fixed geometry and store sizes
    localparam int MAX_PAGE_DEF    = 1024;
    localparam int MIN_PAGE        = 8;
    localparam int MIN_PAGE_LG     = 3;
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = 8;
    localparam int TEXEL_W         = 16;
    localparam int ADDR_OUT_W      = 20;
    localparam int DIM_W           = 11;
    localparam int POS_W           = 10;
    localparam int CFG_IDX_W       = 2;

    // Index mode with alpha keeps the palette color and replaces the alpha nibble
    localparam logic [TEXEL_W-1:0] ALPHA_KEEP_MASK = 16'hFFF0;
    localparam logic [7:0]         ALPHA_OPAQUE    = 8'd255;

    // Input word kinds
    localparam logic OP_CONVERT = 1'b0;
    localparam logic OP_LOAD    = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_HEIGHT  = 2'd2;

    // Pixel formats
    typedef enum logic [2:0] {
        FMT_RGB565      = 3'd0,
        FMT_RGB8        = 3'd1,
        FMT_RGBA8       = 3'd2,
        FMT_INDEX       = 3'd3,
        FMT_INDEX_ALPHA = 3'd4
    } t_fmt;

    // Page geometry as written by software
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_page_cfg;

    // Texel position handed to the address generator
    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
    } t_texel_pos;

    // Keep the high nibble of each channel, red on top
    function automatic logic [TEXEL_W-1:0] pack_rgba4(
        input logic [7:0] r,
        input logic [7:0] g,
        input logic [7:0] b,
        input logic [7:0] a
    );
        return {r[7:4], g[7:4], b[7:4], a[7:4]};
    endfunction

endpackage

// ===== rtl/morton_texture_tiler.sv =====
// Top level of the Morton texture tiler: config, palette, pipeline and output register.
// A convert word passes the stage 1 register, then the output register, before it shows on o_m_*.
// Throughput: one input word per cycle unless o_m_* stalls; palette load words give no result word.
// The two pipeline registers are set by the registered palette read and the output stage.
// Reset (synchronous, active low) clears the valid flags and sets the format to rgb565
// and the page to 8x8; the palette is not cleared and holds garbage until loaded.
`timescale 1ns / 1ps

module morton_texture_tiler #(
    parameter int MAX_PAGE = mtt_pkg::MAX_PAGE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Config write port
    input  logic                           i_cfg_we,
    input  logic [mtt_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [mtt_pkg::DIM_W-1:0]      i_cfg_wdata,
    // Input stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // tdata: col[9:0], row[19:10], entry_index[27:20], byte0[35:28],
    //        byte1[43:36], byte2[51:44], byte3[59:52], zero[63:60]
    input  logic [63:0]                    i_s_tdata,
    // tuser: operation[0]
    input  logic                           i_s_tuser,
    // Output stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // tdata: texel_address[19:0], texel_value[35:20], zero[39:36]
    output logic [39:0]                    o_m_tdata,
    // tuser: out_of_range[0]
    output logic                           o_m_tuser
);

    import mtt_pkg::*;

    // Input word fields
    logic [POS_W-1:0] in_col;
    logic [POS_W-1:0] in_row;
    logic [7:0]       in_entry;
    logic [7:0]       in_b0;
    logic [7:0]       in_b1;
    logic [7:0]       in_b2;
    logic [7:0]       in_b3;
    logic             in_acc;

    assign in_col   = i_s_tdata[9:0];
    assign in_row   = i_s_tdata[19:10];
    assign in_entry = i_s_tdata[27:20];
    assign in_b0    = i_s_tdata[35:28];
    assign in_b1    = i_s_tdata[43:36];
    assign in_b2    = i_s_tdata[51:44];
    assign in_b3    = i_s_tdata[59:52];
    assign in_acc   = i_s_tvalid && o_s_tready;

    // Configuration registers
    logic [2:0] r_fmt;
    t_page_cfg  r_page;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt         <= FMT_RGB565;
            r_page.width  <= DIM_W'(MIN_PAGE);
            r_page.height <= DIM_W'(MIN_PAGE);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_PIXEL_FORMAT: r_fmt         <= i_cfg_wdata[2:0];
                CFG_PAGE_WIDTH:   r_page.width  <= i_cfg_wdata;
                CFG_PAGE_HEIGHT:  r_page.height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Palette: load words write at accept, convert words read at accept
    logic [TEXEL_W-1:0] pal_rdata;

    mtt_ram #(
        .WIDTH (TEXEL_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (in_acc && (i_s_tuser == OP_LOAD)),
        .i_waddr (in_entry),
        .i_wdata (pack_rgba4(in_b0, in_b1, in_b2, in_b3)),
        .i_re    (in_acc && (i_s_tuser == OP_CONVERT)),
        .i_raddr (in_b0),
        .o_rdata (pal_rdata)
    );

    // Stage 1: convert word waiting for its palette data
    logic             r_s1_valid;
    t_texel_pos       r_s1_pos;
    logic [7:0]       r_s1_b0;
    logic [7:0]       r_s1_b1;
    logic [7:0]       r_s1_b2;
    logic [7:0]       r_s1_b3;
    logic             s1_adv;

    // Output register
    logic                  r_out_valid;
    logic [ADDR_OUT_W-1:0] r_out_addr;
    logic [TEXEL_W-1:0]    r_out_val;
    logic                  r_out_oor;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= in_acc && (i_s_tuser == OP_CONVERT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_s_tuser == OP_CONVERT)) begin
            r_s1_pos.col <= in_col;
            r_s1_pos.row <= in_row;
            r_s1_b0      <= in_b0;
            r_s1_b1      <= in_b1;
            r_s1_b2      <= in_b2;
            r_s1_b3      <= in_b3;
        end
    end

    // Address and bounds
    logic [ADDR_OUT_W-1:0] s1_addr;
    logic                  s1_oor;

    mtt_addr_gen #(
        .MAX_PAGE (MAX_PAGE)
    ) u_addr_gen (
        .i_cfg          (r_page),
        .i_pos          (r_s1_pos),
        .o_addr         (s1_addr),
        .o_out_of_range (s1_oor)
    );

    // Texel value by format
    logic [TEXEL_W-1:0] n_out_val;

    always_comb begin
        unique case (r_fmt)
            FMT_RGB565:      n_out_val = {r_s1_b1, r_s1_b0};
            FMT_RGB8:        n_out_val = pack_rgba4(r_s1_b0, r_s1_b1, r_s1_b2, ALPHA_OPAQUE);
            FMT_RGBA8:       n_out_val = pack_rgba4(r_s1_b0, r_s1_b1, r_s1_b2, r_s1_b3);
            FMT_INDEX:       n_out_val = pal_rdata;
            FMT_INDEX_ALPHA: n_out_val = (pal_rdata & ALPHA_KEEP_MASK)
                                         | TEXEL_W'(r_s1_b1[7:4]);
            default:         n_out_val = '0;
        endcase
        if (s1_oor) begin
            n_out_val = '0;
        end
    end

    // Output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_addr <= s1_addr;
            r_out_val  <= n_out_val;
            r_out_oor  <= s1_oor;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_val, r_out_addr};
    assign o_m_tuser  = r_out_oor;

    // Checks
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted while pipeline is full and stalled");

    a_oor_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
        else $error("out of range word carries nonzero data");

    a_convert_enters_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_s_tuser == OP_CONVERT)) |=> r_s1_valid)
        else $error("accepted convert word lost before stage 1");

    a_palette_data_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> $stable(pal_rdata))
        else $error("palette read data changed under a stalled word");

endmodule

// ===== rtl/mtt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module mtt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mtt_addr_gen.sv =====
// Tiled Morton-order address and page bounds check for one texel.
`timescale 1ns / 1ps

module mtt_addr_gen #(
    parameter int MAX_PAGE = mtt_pkg::MAX_PAGE_DEF
) (
    input  mtt_pkg::t_page_cfg                i_cfg,
    input  mtt_pkg::t_texel_pos               i_pos,
    output logic [mtt_pkg::ADDR_OUT_W-1:0]    o_addr,
    output logic                              o_out_of_range
);

    import mtt_pkg::*;

    // Padded sizes run from 2^3 up to 2^LG_P
    localparam int LG_P = $clog2(MAX_PAGE);
    localparam int LGW  = $clog2(LG_P + 4);
    localparam int PW   = LG_P + 1;
    localparam int DW   = (PW > DIM_W) ? PW : DIM_W;
    localparam int CW   = (LG_P > POS_W) ? LG_P : POS_W;
    localparam int AW   = 2 * LG_P;

    // Log2 of the padded size: smallest power of two covering the dimension, clamped to 2^3..2^LG_P
    function automatic logic [LGW-1:0] padded_lg(input logic [DIM_W-1:0] v);
        logic [LGW-1:0] lg;
        lg = LGW'(MIN_PAGE_LG);
        for (int k = MIN_PAGE_LG; k < LG_P; k++) begin
            if (32'(v) > (32'd1 << k)) begin
                lg = LGW'(k + 1);
            end
        end
        return lg;
    endfunction

    logic [LGW-1:0]  lg_w;
    logic [LGW-1:0]  lg_h;
    logic [PW-1:0]   pw;
    logic [PW-1:0]   ph;
    logic [DW-1:0]   ew;
    logic [DW-1:0]   eh;
    logic [LG_P-1:0] ph_m1;
    logic [CW-1:0]   m_full;
    logic [LG_P-1:0] m;
    logic [LG_P-1:0] c;
    logic [5:0]      tile;
    logic [AW-1:0]   addr_hi;
    logic [AW-1:0]   addr_mid;
    logic [AW-1:0]   addr_full;

    // Padded and effective page dimensions
    always_comb begin
        lg_w = padded_lg(i_cfg.width);
        lg_h = padded_lg(i_cfg.height);
        pw   = PW'(1) << lg_w;
        ph   = PW'(1) << lg_h;
        ew   = (DW'(i_cfg.width)  < DW'(pw)) ? DW'(i_cfg.width)  : DW'(pw);
        eh   = (DW'(i_cfg.height) < DW'(ph)) ? DW'(i_cfg.height) : DW'(ph);
    end

    assign o_out_of_range = (DW'(i_pos.col) >= ew) || (DW'(i_pos.row) >= eh);

    // Rows stored bottom-up; tiles of 64 texels, tile rows of pw*8 texels.
    // Column tiles stay below one tile row, so the terms do not overlap.
    always_comb begin
        ph_m1     = LG_P'(ph - PW'(1));
        m_full    = CW'(ph_m1) - CW'(i_pos.row);
        m         = m_full[LG_P-1:0];
        c         = LG_P'(i_pos.col);
        tile      = {m[2], c[2], m[1], c[1], m[0], c[0]};
        addr_hi   = AW'(m >> 3) << (lg_w + LGW'(3));
        addr_mid  = AW'(c >> 3) << 6;
        addr_full = addr_hi | addr_mid | AW'(tile);
    end

    assign o_addr = o_out_of_range ? '0 : ADDR_OUT_W'(addr_full);

endmodule
